[hw/rtl/quadrature_decoder_with_error_tally_defines.svh]
// Assertion macros used by the quadrature decoder core (qdet_core).
`ifndef QUADRATURE_DECODER_WITH_ERROR_TALLY_DEFINES_SVH
`define QUADRATURE_DECODER_WITH_ERROR_TALLY_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define QDET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define QDET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define QDET_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define QDET_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

[hw/rtl/qdet_pkg.sv]
// Shared types, constants and transition table for the quadrature decoder.
`default_nettype none
package qdet_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int TALLY_WIDTH = 32;
	localparam int OUT_WIDTH   = 32;
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 104;
	localparam int CFG_IDX_W   = 2;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic [COUNT_WIDTH-1:0] COUNT_MIN = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
	localparam logic [TALLY_WIDTH-1:0] TALLY_TOP = {TALLY_WIDTH{1'b1}};

	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_BAD  = 2'd2,
		STEP_DOWN = 2'd3
	} step_code_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_A = 2'd0,
		REG_START_B = 2'd1,
		REG_REVERSE = 2'd2
	} cfg_reg_t;

	// index = previous pair * 4 + new pair, pair = {a, b}
	localparam step_code_t STEP_TABLE [16] = '{
		STEP_NONE, STEP_UP,   STEP_DOWN, STEP_BAD,
		STEP_DOWN, STEP_NONE, STEP_BAD,  STEP_UP,
		STEP_UP,   STEP_BAD,  STEP_NONE, STEP_DOWN,
		STEP_BAD,  STEP_DOWN, STEP_UP,   STEP_NONE
	};

	typedef struct packed {
		logic           we;
		logic [CFG_IDX_W-1:0] index;
		logic           data;
	} cfg_wr_t;

	typedef struct packed {
		logic                        held_b;
		logic                        held_a;
		logic                        overflow_seen;
		logic                        bad_seen;
		logic        [OUT_WIDTH-1:0] bad_steps;
		logic        [OUT_WIDTH-1:0] good_steps;
		logic signed [OUT_WIDTH-1:0] position;
		logic signed [1:0]           step_applied;
	} result_t;

endpackage
`default_nettype wire

[hw/rtl/quadrature_decoder_with_error_tally.sv]
// Top level of the x4 quadrature decoder with transition tallies.
//
// Usage: each input beat on the s_ channel carries one A/B sample. It is
// compared with the stored pair; a single-bit change moves the position by
// one (negated when reverse_direction is set) until it saturates, a
// double-bit jump counts as invalid. Every sample yields exactly one result
// beat on the m_ channel with the full snapshot: step, position, both
// tallies, sticky flags and the stored pair.
// Path: a sample accepted on s_ passes the input register, then the result
// register, before it shows on m_tvalid. Throughput: one beat per cycle while
// the receiver takes them; position, tallies and stored pair update once per sample.
// When the receiver stalls, the result register holds and the input
// register fills; s_tready drops only once both are occupied.
// Reset clears count, tallies, flags, direction and start levels; the stored
// pair resets to 00. A start_level_a/b write loads that bit into the pair
// unless a sample advances; write configuration only while the block is idle.
`default_nettype none
module quadrature_decoder_with_error_tally (
	input  wire logic clk,
	input  wire logic arst_n,
	// fields from bit 0: level_a, level_b, zero pad
	input  wire logic [qdet_pkg::IN_TDATA_W-1:0] s_tdata,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// fields from bit 0: step_applied[1:0], position[31:0], good_steps[31:0],
	// bad_steps[31:0], bad_seen, overflow_seen, held_a, held_b, zero pad
	output logic [qdet_pkg::OUT_TDATA_W-1:0] m_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	input  wire logic cfg_we,
	input  wire logic [qdet_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic cfg_data
);
	import qdet_pkg::*;

	logic       valid_s1;
	logic [1:0] sample_s1;
	logic       obuf_ready;
	logic       advance;
	cfg_wr_t    cfg;
	result_t    res;

	assign advance  = valid_s1 && obuf_ready;
	assign s_tready = !valid_s1 || obuf_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			sample_s1 <= {s_tdata[0], s_tdata[1]};
		end
	end

	always_comb begin
		cfg.we    = cfg_we;
		cfg.index = cfg_index;
		cfg.data  = cfg_data;
	end

	qdet_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.advance (advance),
		.sample  (sample_s1),
		.res     (res)
	);

	qdet_obuf u_obuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1),
		.res      (res),
		.ready    (obuf_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);
endmodule
`default_nettype wire

[hw/rtl/qdet_core.sv]
// Decoder state and single-pass transition update for one sample.
`default_nettype none
`include "quadrature_decoder_with_error_tally_defines.svh"
module qdet_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire qdet_pkg::cfg_wr_t cfg,
	input  wire logic              advance,
	input  wire logic [1:0]        sample,
	output qdet_pkg::result_t      res
);
	import qdet_pkg::*;

	logic [1:0]             pair_q;
	logic                   reverse_q;
	logic [COUNT_WIDTH-1:0] pos_q;
	logic [TALLY_WIDTH-1:0] good_q;
	logic [TALLY_WIDTH-1:0] bad_q;
	logic                   bad_seen_q;
	logic                   ovf_q;

	step_code_t             code;
	logic                   is_step;
	logic                   up;
	logic                   hit_limit;
	logic                   move;
	logic [COUNT_WIDTH-1:0] pos_d;
	logic [TALLY_WIDTH-1:0] good_d;
	logic [TALLY_WIDTH-1:0] bad_d;
	logic                   bad_seen_d;
	logic                   ovf_d;
	logic signed [1:0]      step_d;

	always_comb begin
		code      = STEP_TABLE[{pair_q, sample}];
		is_step   = (code == STEP_UP) || (code == STEP_DOWN);
		up        = (code == STEP_UP) ^ reverse_q;
		hit_limit = up ? (pos_q == COUNT_MAX) : (pos_q == COUNT_MIN);
		move      = is_step && !ovf_q && !hit_limit;
		ovf_d     = ovf_q || (is_step && hit_limit);
		pos_d     = pos_q;
		step_d    = 2'sd0;
		if (move) begin
			pos_d  = up ? pos_q + COUNT_WIDTH'(1) : pos_q - COUNT_WIDTH'(1);
			step_d = up ? 2'sd1 : -2'sd1;
		end
		good_d     = (is_step && good_q != TALLY_TOP) ? good_q + TALLY_WIDTH'(1) : good_q;
		bad_d      = (code == STEP_BAD && bad_q != TALLY_TOP) ? bad_q + TALLY_WIDTH'(1) : bad_q;
		bad_seen_d = bad_seen_q || (code == STEP_BAD);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_q     <= 2'b00;
			reverse_q  <= 1'b0;
			pos_q      <= '0;
			good_q     <= '0;
			bad_q      <= '0;
			bad_seen_q <= 1'b0;
			ovf_q      <= 1'b0;
		end else if (advance) begin
			pair_q     <= sample;
			pos_q      <= pos_d;
			good_q     <= good_d;
			bad_q      <= bad_d;
			bad_seen_q <= bad_seen_d;
			ovf_q      <= ovf_d;
		end else if (cfg.we) begin
			unique case (cfg.index)
				REG_START_A: pair_q[1] <= cfg.data;
				REG_START_B: pair_q[0] <= cfg.data;
				REG_REVERSE: reverse_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		res.step_applied  = step_d;
		res.position      = OUT_WIDTH'(signed'(pos_d));
		res.good_steps    = OUT_WIDTH'(good_d);
		res.bad_steps     = OUT_WIDTH'(bad_d);
		res.bad_seen      = bad_seen_d;
		res.overflow_seen = ovf_d;
		res.held_a        = sample[1];
		res.held_b        = sample[0];
	end

	`QDET_ASSERT_NXT(a_ovf_sticky, clk, arst_n, ovf_q, ovf_q, "overflow flag cleared")
	`QDET_ASSERT_NXT(a_bad_sticky, clk, arst_n, bad_seen_q, bad_seen_q, "bad flag cleared")
	`QDET_ASSERT_NXT(a_frozen, clk, arst_n, ovf_q, $stable(pos_q), "count moved after overflow")
	`QDET_ASSERT_NXT(a_bad_flag, clk, arst_n, advance && code == STEP_BAD, bad_seen_q,
		"invalid jump not flagged")
endmodule
`default_nettype wire

[hw/rtl/qdet_obuf.sv]
// Result register between the decoder and the output stream.
`default_nettype none
module qdet_obuf (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              load,
	input  wire qdet_pkg::result_t res,
	output logic                   ready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [qdet_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import qdet_pkg::*;

	logic    valid_q;
	result_t res_q;

	assign ready = !valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			res_q <= res;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = OUT_TDATA_W'(res_q);
endmodule
`default_nettype wire
